// ===== rtl/key_value_table_unit_assert.svh =====
// Assertion macros shared by the key/value table checker.
`ifndef KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("key_value_table_unit: assertion failed");

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("key_value_table_unit: assertion failed");

`endif

// ===== rtl/kvt_pkg.sv =====
// Shared types and constants of the key/value table.
package kvt_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Stream field widths and positions
    localparam int ACTION_W    = 2;
    localparam int KEY_IN_W    = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int STATUS_W    = 3;
    localparam int VALUE_OUT_W = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam int IN_KEY_LSB    = ACTION_W;
    localparam int IN_VALUE_LSB  = ACTION_W + KEY_IN_W;
    localparam int IN_USED_W     = ACTION_W + KEY_IN_W + VALUE_IN_W;
    localparam int OUT_VALUE_LSB = STATUS_W;
    localparam int OUT_USED_W    = STATUS_W + VALUE_OUT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_HOLD = 2'd2
    } t_state;

    // Request token that walks the cell row
    typedef struct packed {
        logic    active;
        t_action action;
        logic    hit;
        logic    free_seen;
    } t_probe;

endpackage

// ===== rtl/key_value_table_unit.sv =====
// Key/value table top level: stream ports, request sequencer and the row of entry cells.
// A request (lookup, insert or update, delete, clear) is a token that walks the row of
// ENTRIES cells one cell per clock; each cell compares its key, acts on a match and notes
// whether it is free. When the token leaves the last cell an insert without a match is
// written into the lowest free entry, and the result goes to the output register.
// A request walks the cell row, then a resolve step fills the result registers and
// a load moves them into the output register; the next request is taken the cycle
// after that load, so no new request is taken until the last result is registered.
// A result still waiting in the output register holds the next one back and stalls
// the input. No clearing pass is needed after reset: the valid bits clear at once.
module key_value_table_unit #(
    parameter int ENTRIES     = kvt_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action[1:0], key[33:2], value_in[65:34], zero fill[71:66]
    input  logic [kvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[2:0], value_out[34:3], zero fill[39:35]
    output logic [kvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kvt_pkg::t_state                   r_state, n_state;
    kvt_pkg::t_probe                   r_inject, n_inject;
    logic [KEY_WIDTH-1:0]              r_req_key, n_req_key;
    logic [VALUE_WIDTH-1:0]            r_req_value, n_req_value;
    kvt_pkg::t_status                  r_res_status, n_res_status;
    logic [kvt_pkg::VALUE_OUT_W-1:0]   r_res_value, n_res_value;
    logic                              r_out_valid, n_out_valid;
    kvt_pkg::t_status                  r_out_status, n_out_status;
    logic [kvt_pkg::VALUE_OUT_W-1:0]   r_out_value, n_out_value;
    logic                              w_accept;
    logic                              w_wr_en;

    kvt_pkg::t_probe                   w_probe     [ENTRIES+1];
    logic [VALUE_WIDTH-1:0]            w_hit_value [ENTRIES+1];
    logic [IDX_W-1:0]                  w_free_idx  [ENTRIES+1];

    kvt_pkg::t_probe                   w_last;

    assign w_last = w_probe[ENTRIES];

    // Feed the head of the row
    assign w_probe[0]     = r_inject;
    assign w_hit_value[0] = '0;
    assign w_free_idx[0]  = '0;

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_req_key),
            .i_value     (r_req_value),
            .i_probe     (w_probe[g]),
            .i_hit_value (w_hit_value[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_wr_en     (w_wr_en),
            .i_wr_idx    (w_free_idx[ENTRIES]),
            .o_probe     (w_probe[g+1]),
            .o_hit_value (w_hit_value[g+1]),
            .o_free_idx  (w_free_idx[g+1])
        );
    end

    // Sequence one request: accept, walk, finish, hand to the output register
    always_comb begin
        n_state      = r_state;
        n_inject     = '0;
        n_req_key    = r_req_key;
        n_req_value  = r_req_value;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        w_accept     = 1'b0;
        w_wr_en      = 1'b0;
        case (r_state)
            kvt_pkg::S_IDLE: begin
                w_accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_inject.active = 1'b1;
                    n_inject.action = kvt_pkg::t_action'(s_axis_tdata[kvt_pkg::ACTION_W-1:0]);
                    n_req_key       = KEY_WIDTH'(
                        s_axis_tdata[kvt_pkg::IN_VALUE_LSB-1:kvt_pkg::IN_KEY_LSB]);
                    n_req_value     = VALUE_WIDTH'(
                        s_axis_tdata[kvt_pkg::IN_USED_W-1:kvt_pkg::IN_VALUE_LSB]);
                    n_state         = kvt_pkg::S_WALK;
                end
            end
            kvt_pkg::S_WALK: begin
                if (w_last.active) begin
                    n_res_value = '0;
                    case (w_last.action)
                        kvt_pkg::ACT_LOOKUP: begin
                            if (w_last.hit) begin
                                n_res_status = kvt_pkg::ST_FOUND;
                                n_res_value  = kvt_pkg::VALUE_OUT_W'(w_hit_value[ENTRIES]);
                            end else begin
                                n_res_status = kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kvt_pkg::ACT_INSERT: begin
                            if (w_last.hit) begin
                                n_res_status = kvt_pkg::ST_UPDATED;
                            end else if (w_last.free_seen) begin
                                n_res_status = kvt_pkg::ST_INSERTED;
                                w_wr_en      = 1'b1;
                            end else begin
                                n_res_status = kvt_pkg::ST_FULL;
                            end
                        end
                        kvt_pkg::ACT_DELETE: begin
                            n_res_status = w_last.hit ? kvt_pkg::ST_DELETED
                                                      : kvt_pkg::ST_NOT_FOUND;
                        end
                        kvt_pkg::ACT_CLEAR: begin
                            n_res_status = kvt_pkg::ST_DELETED;
                        end
                        default: begin
                            n_res_status = kvt_pkg::ST_NOT_FOUND;
                        end
                    endcase
                    n_state = kvt_pkg::S_HOLD;
                end
            end
            kvt_pkg::S_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_state      = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kvt_pkg::S_IDLE;
            r_inject    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inject    <= n_inject;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_req_key    <= n_req_key;
        r_req_value  <= n_req_value;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    // Take no request beat while in reset
    assign s_axis_tready = i_rst_n && (w_accept || (r_state == kvt_pkg::S_IDLE));
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(kvt_pkg::OUT_TDATA_W - kvt_pkg::OUT_USED_W){1'b0}},
        r_out_value,
        r_out_status
    };

endmodule

// ===== rtl/kvt_cell.sv =====
// One table entry: key, value and valid bit, with the token stage that passes it.
module kvt_cell #(
    parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = 4,
    parameter int CELL_IDX    = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  kvt_pkg::t_probe        i_probe,
    input  logic [VALUE_WIDTH-1:0] i_hit_value,
    input  logic [IDX_W-1:0]       i_free_idx,
    input  logic                   i_wr_en,
    input  logic [IDX_W-1:0]       i_wr_idx,
    output kvt_pkg::t_probe        o_probe,
    output logic [VALUE_WIDTH-1:0] o_hit_value,
    output logic [IDX_W-1:0]       o_free_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                   r_valid, n_valid;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    kvt_pkg::t_probe        r_probe, n_probe;
    logic [VALUE_WIDTH-1:0] r_hit_value, n_hit_value;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   w_match;

    // Act on the passing token, then take a new entry from the write broadcast
    always_comb begin
        w_match     = r_valid && (r_key == i_key);
        n_valid     = r_valid;
        n_key       = r_key;
        n_value     = r_value;
        n_probe     = i_probe;
        n_hit_value = i_hit_value;
        n_free_idx  = i_free_idx;
        if (i_probe.active) begin
            case (i_probe.action)
                kvt_pkg::ACT_LOOKUP: begin
                    if (w_match) begin
                        n_probe.hit = 1'b1;
                        n_hit_value = r_value;
                    end
                end
                kvt_pkg::ACT_INSERT: begin
                    if (w_match) begin
                        n_probe.hit = 1'b1;
                        n_value     = i_value;
                    end
                end
                kvt_pkg::ACT_DELETE: begin
                    if (w_match) begin
                        n_probe.hit = 1'b1;
                        n_valid     = 1'b0;
                    end
                end
                kvt_pkg::ACT_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
            // Record the lowest free entry seen so far
            if (!r_valid && !i_probe.free_seen) begin
                n_probe.free_seen = 1'b1;
                n_free_idx        = MY_IDX;
            end
        end
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            n_valid = 1'b1;
            n_key   = i_key;
            n_value = i_value;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_probe <= '0;
        end else begin
            r_valid <= n_valid;
            r_probe <= n_probe;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_value     <= n_value;
        r_hit_value <= n_hit_value;
        r_free_idx  <= n_free_idx;
    end

    assign o_probe     = r_probe;
    assign o_hit_value = r_hit_value;
    assign o_free_idx  = r_free_idx;

endmodule

// ===== rtl/kvt_checker.sv =====
// Port-level checks of the key/value table, bound to the top level.
`include "key_value_table_unit_assert.svh"

module kvt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kvt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic w_in_beat;
    logic w_out_stall;
    logic w_not_found_hit;
    logic w_pad_zero;

    assign w_in_beat       = s_axis_tvalid && s_axis_tready;
    assign w_out_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_not_found_hit = m_axis_tvalid &&
        (m_axis_tdata[kvt_pkg::STATUS_W-1:0] != kvt_pkg::ST_FOUND);
    assign w_pad_zero      = (m_axis_tdata[kvt_pkg::OUT_TDATA_W-1:kvt_pkg::OUT_USED_W] == '0);

    // Hold a stalled result beat
    `KVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall,
        m_axis_tvalid && $stable(m_axis_tdata))

    // Busy after a request beat: no ready and no new result
    `KVT_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat,
        !s_axis_tready && !$rose(m_axis_tvalid))

    // Drive a value only for a found lookup
    `KVT_ASSERT_NOW(a_value_only_found, i_clk, i_rst_n, w_not_found_hit,
        m_axis_tdata[kvt_pkg::OUT_USED_W-1:kvt_pkg::OUT_VALUE_LSB] == '0)

    // Keep the fill bits and status code in range on every result beat
    `KVT_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_axis_tvalid,
        w_pad_zero && (m_axis_tdata[kvt_pkg::STATUS_W-1:0] <= kvt_pkg::ST_FULL))

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/key_value_table_checker.sv =====
// Stream monitor for the key/value table: tracks the store, predicts each reply and compares it.
module key_value_table_checker
    import kvt_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_tvalid,
    input  logic                   i_req_tready,
    // action[1:0], key[33:2], value_in[65:34], zero fill[71:66]
    input  logic [IN_TDATA_W-1:0]  i_req_tdata,
    input  logic                   i_rsp_tvalid,
    input  logic                   i_rsp_tready,
    // status[2:0], value_out[34:3], zero fill[39:35]
    input  logic [OUT_TDATA_W-1:0] i_rsp_tdata,
    output int                     o_errors,
    output int                     o_outstanding
);

    localparam logic [KEY_IN_W-1:0] KEY_MASK = (KEY_WIDTH >= KEY_IN_W) ? {KEY_IN_W{1'b1}} :
        ({KEY_IN_W{1'b1}} >> (KEY_IN_W - KEY_WIDTH));
    localparam logic [VALUE_IN_W-1:0] VALUE_MASK = (VALUE_WIDTH >= VALUE_IN_W) ?
        {VALUE_IN_W{1'b1}} : ({VALUE_IN_W{1'b1}} >> (VALUE_IN_W - VALUE_WIDTH));
    localparam int MAX_PRINTED = 100;

    typedef struct {
        t_status                 status;
        logic [VALUE_OUT_W-1:0]  value;
    } t_reply;

    // Shadow copy of the store
    logic                  slot_valid [ENTRIES];
    logic [KEY_IN_W-1:0]   slot_key   [ENTRIES];
    logic [VALUE_IN_W-1:0] slot_value [ENTRIES];

    t_reply pending_replies [$];
    int     mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Apply one request to the shadow store and return the reply it must produce
    function automatic t_reply apply_request(input logic [IN_TDATA_W-1:0] beat);
        t_action               act;
        logic [KEY_IN_W-1:0]   req_key;
        logic [VALUE_IN_W-1:0] req_value;
        t_reply                reply;
        int                    hit;
        int                    free_slot;
        act       = t_action'(beat[ACTION_W-1:0]);
        req_key   = beat[IN_KEY_LSB +: KEY_IN_W] & KEY_MASK;
        req_value = beat[IN_VALUE_LSB +: VALUE_IN_W] & VALUE_MASK;
        reply.status = ST_NOT_FOUND;
        reply.value  = '0;
        hit       = -1;
        free_slot = -1;
        // Scan from the top so the lowest index wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_key[i] == req_key) hit = i;
            if (!slot_valid[i]) free_slot = i;
        end
        case (act)
            ACT_LOOKUP: begin
                if (hit >= 0) begin
                    reply.status = ST_FOUND;
                    reply.value  = slot_value[hit];
                end
            end
            ACT_INSERT: begin
                if (hit >= 0) begin
                    slot_value[hit] = req_value;
                    reply.status    = ST_UPDATED;
                end else if (free_slot >= 0) begin
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot]   = req_key;
                    slot_value[free_slot] = req_value;
                    reply.status          = ST_INSERTED;
                end else begin
                    reply.status = ST_FULL;
                end
            end
            ACT_DELETE: begin
                if (hit >= 0) begin
                    slot_valid[hit] = 1'b0;
                    reply.status    = ST_DELETED;
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
                reply.status = ST_DELETED;
            end
        endcase
        return reply;
    endfunction

    // Compare each result beat first, then record the request beat of the same edge
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
            pending_replies.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("result beat with no request waiting");
                end else begin
                    want = pending_replies.pop_front();
                    if (i_rsp_tdata[STATUS_W-1:0] !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                            i_rsp_tdata[STATUS_W-1:0], want.status));
                    end
                    if (i_rsp_tdata[OUT_VALUE_LSB +: VALUE_OUT_W] !== want.value) begin
                        report_mismatch($sformatf("value_out %h, expected %h",
                            i_rsp_tdata[OUT_VALUE_LSB +: VALUE_OUT_W], want.value));
                    end
                end
            end
            if (i_req_tvalid && i_req_tready) begin
                pending_replies.push_back(apply_request(i_req_tdata));
            end
        end
        o_outstanding <= pending_replies.size();
    end

endmodule

// ===== tb/sv/tb_key_value_table_unit.sv =====
// Testbench top for the key/value table: clock, reset, request and result traffic, verdict.
module tb_key_value_table_unit;
    import kvt_pkg::*;

    localparam int TOTAL_ITEMS  = 1500;
    localparam int POOL_SIZE    = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AT      = 400;
    localparam int PAUSE_AT     = 1000;
    localparam int QUIET_FIRST  = 650;
    localparam int QUIET_LAST   = 900;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = ENTRIES_DEF + 8;
    localparam int EP_FILL      = 0;
    localparam int EP_NOISE     = 3;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int   checker_errors;
    int   outstanding;
    int   sent_count  = 0;
    logic quiet_phase = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;

    always #1 i_clk = ~i_clk;

    key_value_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    key_value_table_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_tvalid  (s_axis_tvalid),
        .i_req_tready  (s_axis_tready),
        .i_req_tdata   (s_axis_tdata),
        .i_rsp_tvalid  (m_axis_tvalid),
        .i_rsp_tready  (m_axis_tready),
        .i_rsp_tdata   (m_axis_tdata),
        .o_errors      (checker_errors),
        .o_outstanding (outstanding)
    );

    // Offer one request beat after a random gap and hold it until accepted
    task automatic send_request(input t_action act, input logic [31:0] req_key,
                                input logic [31:0] req_value);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < 13) gap++;
        if ($urandom_range(0, 99) < 4) gap += $urandom_range(1, 30);
        if (quiet_phase) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, req_value, req_key, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Wait until every expected result has come back, bounded
    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        @(posedge i_clk);
        while (outstanding != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Result side: random stalls and one long hold-off
    initial begin : sink
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                for (int held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end else begin
                m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 13);
                @(posedge i_clk);
            end
        end
    end

    // Request side and verdict
    initial begin : source
        logic [31:0] key_pool [POOL_SIZE];
        logic [31:0] req_key;
        t_action     act;
        int          episode;
        int          len;
        int          roll;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, key and value extremes, update, delete, clear
        send_request(ACT_CLEAR,  32'h0,          32'h0);
        send_request(ACT_LOOKUP, 32'h0,          ALL_ONES);
        send_request(ACT_DELETE, ALL_ONES,       32'h0);
        send_request(ACT_INSERT, 32'h0,          ALL_ONES);
        send_request(ACT_INSERT, ALL_ONES,       32'h0);
        send_request(ACT_LOOKUP, 32'h0,          32'h0);
        send_request(ACT_LOOKUP, ALL_ONES,       ALL_ONES);
        send_request(ACT_INSERT, 32'h0,          32'h1234_5678);
        send_request(ACT_LOOKUP, 32'h0,          32'h0);
        send_request(ACT_DELETE, 32'h0,          ALL_ONES);
        send_request(ACT_LOOKUP, 32'h0,          32'h0);
        send_request(ACT_DELETE, 32'h0,          32'h0);
        send_request(ACT_INSERT, 32'hAAAA_5555,  32'h5555_AAAA);
        send_request(ACT_LOOKUP, 32'h5555_AAAA,  32'h0);
        send_request(ACT_CLEAR,  ALL_ONES,       ALL_ONES);
        send_request(ACT_LOOKUP, ALL_ONES,       32'h0);

        // Random episodes over a small key pool so the store fills and drains
        while (sent_count < TOTAL_ITEMS) begin
            episode = $urandom_range(0, 3);
            for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
            if ($urandom_range(0, 3) == 0) key_pool[0] = 32'h0;
            if ($urandom_range(0, 3) == 0) key_pool[1] = ALL_ONES;
            len = $urandom_range(20, 60);
            for (int n = 0; n < len && sent_count < TOTAL_ITEMS; n++) begin
                if (sent_count == HOLD_AT) hold_req = 1'b1;
                if (sent_count == PAUSE_AT) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained(DRAIN_LIMIT);
                end
                quiet_phase = (sent_count >= QUIET_FIRST && sent_count < QUIET_LAST);
                roll = $urandom_range(0, 99);
                if (episode == EP_NOISE) begin
                    act = t_action'($urandom_range(0, 3));
                end else if (episode == EP_FILL) begin
                    act = (roll < 70) ? ACT_INSERT : (roll < 85) ? ACT_LOOKUP :
                          (roll < 97) ? ACT_DELETE : ACT_LOOKUP;
                end else begin
                    act = (roll < 40) ? ACT_INSERT : (roll < 70) ? ACT_LOOKUP :
                          (roll < 96) ? ACT_DELETE : ACT_CLEAR;
                end
                if (episode != EP_NOISE && $urandom_range(0, 99) < 85) begin
                    req_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else begin
                    req_key = $urandom();
                end
                send_request(act, req_key, $urandom());
            end
        end
        quiet_phase = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, let any stray beat show up, then judge
        wait_drained(DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outstanding != 0) begin
            $display("ERROR: %0d results never arrived", outstanding);
        end
        if (checker_errors == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop for a hung run
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== key_value_table_unit.f =====
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/key_value_table_unit.sv
rtl/kvt_checker.sv
tb/sv/key_value_table_checker.sv
tb/sv/tb_key_value_table_unit.sv
